// ===== hw/rtl/clhs_pkg.sv =====
// Shared types, codes and a helper function for the circular log head search.
`timescale 1ns / 1ps

package clhs_pkg;

  localparam int BLOCK_NUMBER_BITS = 32;
  localparam int UNIQUE_ID_BITS    = 32;
  localparam int FIELD_BITS        = 32;

  typedef logic [BLOCK_NUMBER_BITS-1:0] bn_t;
  typedef logic [UNIQUE_ID_BITS-1:0]    uid_t;
  typedef logic [FIELD_BITS-1:0]        field_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_FIRST,
    PH_LAST,
    PH_SEARCH,
    PH_SESSION
  } phase_t;

  localparam logic       MODE_START   = 1'b0;
  localparam logic       KIND_REQUEST = 1'b0;
  localparam logic       KIND_DONE    = 1'b1;
  localparam logic [1:0] STATUS_FOUND = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_RDERR = 2'd2;

  localparam field_t LINK_UNSET = '1;

  typedef struct packed {
    phase_t phase;
    logic   circular_mode;
    bn_t    left_block;
    bn_t    right_block;
    bn_t    middle_block;
    uid_t   left_id;
    uid_t   right_id;
    uid_t   left_session_id;
    bn_t    left_session_first;
    bn_t    found_block;
    uid_t   found_id;
    uid_t   found_session_id;
    bn_t    found_session_first;
  } search_state_t;

  typedef struct packed {
    logic   mode;
    logic   read_ok;
    logic   magic_valid;
    field_t block_id;
    field_t hdr_session_id;
    field_t hdr_session_first;
    field_t hdr_next_session_first;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    field_t     read_block;
    logic [1:0] status;
    field_t     newest_block;
    field_t     newest_block_id;
    field_t     session_id;
    field_t     session_first;
    field_t     session_next;
    field_t     session_length;
  } result_t;

  typedef struct packed {
    logic done;
    bn_t  mid;
  } split_t;

  // One bisection step: done when the interval has closed to adjacent blocks.
  function automatic split_t split_step(bn_t lo, bn_t hi);
    split_t s;
    bn_t    span;
    span   = hi - lo;
    s.done = (bn_t'(lo + bn_t'(1)) == hi);
    s.mid  = lo + (span >> 1);
    return s;
  endfunction

endpackage

// ===== hw/rtl/clhs_step.sv =====
// Next-state and result logic for one item of the head search.
`timescale 1ns / 1ps

module clhs_step (
  input  clhs_pkg::search_state_t st,
  input  clhs_pkg::in_item_t      item,
  input  clhs_pkg::field_t        log_size,
  output clhs_pkg::search_state_t st_nxt,
  output logic                    has_result,
  output clhs_pkg::result_t       result
);

  clhs_pkg::bn_t    eff_size;
  clhs_pkg::uid_t   bid;
  clhs_pkg::uid_t   sid;
  clhs_pkg::bn_t    sfirst;
  clhs_pkg::split_t sp_last;
  clhs_pkg::split_t sp_gl;
  clhs_pkg::split_t sp_gr;
  clhs_pkg::split_t sp;
  logic             go_left;
  clhs_pkg::bn_t    cand_block;
  clhs_pkg::uid_t   cand_id;
  clhs_pkg::uid_t   cand_sid;
  clhs_pkg::bn_t    cand_sfirst;
  logic             do_split;
  clhs_pkg::bn_t    sess_len;

  assign bid    = clhs_pkg::uid_t'(item.block_id);
  assign sid    = clhs_pkg::uid_t'(item.hdr_session_id);
  assign sfirst = clhs_pkg::bn_t'(item.hdr_session_first);

  always_comb begin
    eff_size = clhs_pkg::bn_t'(log_size);
    if (eff_size < clhs_pkg::bn_t'(2)) begin
      eff_size = clhs_pkg::bn_t'(2);
    end
  end

  // All three possible bisections are formed in parallel, then selected.
  assign sp_last = clhs_pkg::split_step(st.left_block, st.right_block);
  assign sp_gl   = clhs_pkg::split_step(st.left_block, st.middle_block);
  assign sp_gr   = clhs_pkg::split_step(st.middle_block, st.right_block);

  // Wrap-aware: left if left-to-mid ID gap is larger; linear: left if invalid.
  assign go_left = st.circular_mode ?
                   (clhs_pkg::uid_t'(bid - st.left_id) > clhs_pkg::uid_t'(st.right_id - bid)) :
                   !item.magic_valid;

  always_comb begin
    sess_len = '0;
    if (item.hdr_next_session_first != clhs_pkg::LINK_UNSET) begin
      if (st.found_block >= st.found_session_first) begin
        sess_len = st.found_block - st.found_session_first + clhs_pkg::bn_t'(1);
      end else begin
        sess_len = st.found_block + eff_size - st.found_session_first + clhs_pkg::bn_t'(1);
      end
    end
  end

  always_comb begin
    st_nxt      = st;
    has_result  = 1'b0;
    result      = '0;
    do_split    = 1'b0;
    sp          = sp_last;
    cand_block  = st.left_block;
    cand_id     = st.left_id;
    cand_sid    = st.left_session_id;
    cand_sfirst = st.left_session_first;

    if (item.mode == clhs_pkg::MODE_START) begin
      st_nxt.left_block    = '0;
      st_nxt.right_block   = eff_size - clhs_pkg::bn_t'(1);
      st_nxt.circular_mode = 1'b0;
      st_nxt.phase         = clhs_pkg::PH_FIRST;
      has_result           = 1'b1;
      result.kind          = clhs_pkg::KIND_REQUEST;
    end else if (st.phase != clhs_pkg::PH_IDLE) begin
      has_result = 1'b1;
      if (!item.read_ok) begin
        st_nxt.phase  = clhs_pkg::PH_IDLE;
        result.kind   = clhs_pkg::KIND_DONE;
        result.status = clhs_pkg::STATUS_RDERR;
      end else begin
        case (st.phase)
          clhs_pkg::PH_FIRST: begin
            if (!item.magic_valid) begin
              st_nxt.phase  = clhs_pkg::PH_IDLE;
              result.kind   = clhs_pkg::KIND_DONE;
              result.status = clhs_pkg::STATUS_EMPTY;
            end else begin
              st_nxt.left_id            = bid;
              st_nxt.left_session_id    = sid;
              st_nxt.left_session_first = sfirst;
              st_nxt.phase              = clhs_pkg::PH_LAST;
              result.kind               = clhs_pkg::KIND_REQUEST;
              result.read_block         = clhs_pkg::field_t'(st.right_block);
            end
          end
          clhs_pkg::PH_LAST: begin
            if (!item.magic_valid) begin
              st_nxt.circular_mode = 1'b0;
              do_split             = 1'b1;
            end else begin
              st_nxt.right_id = bid;
              if (clhs_pkg::uid_t'(bid + clhs_pkg::uid_t'(1)) != st.left_id) begin
                // ID break at the border: the last block is the newest
                st_nxt.found_block         = st.right_block;
                st_nxt.found_id            = bid;
                st_nxt.found_session_id    = sid;
                st_nxt.found_session_first = sfirst;
                st_nxt.phase               = clhs_pkg::PH_SESSION;
                result.kind                = clhs_pkg::KIND_REQUEST;
                result.read_block          = clhs_pkg::field_t'(sfirst);
              end else begin
                st_nxt.circular_mode = 1'b1;
                do_split             = 1'b1;
              end
            end
          end
          clhs_pkg::PH_SEARCH: begin
            do_split = 1'b1;
            if (go_left) begin
              st_nxt.right_block = st.middle_block;
              st_nxt.right_id    = bid;
              sp                 = sp_gl;
            end else begin
              st_nxt.left_block         = st.middle_block;
              st_nxt.left_id            = bid;
              st_nxt.left_session_id    = sid;
              st_nxt.left_session_first = sfirst;
              sp                        = sp_gr;
              cand_block                = st.middle_block;
              cand_id                   = bid;
              cand_sid                  = sid;
              cand_sfirst               = sfirst;
            end
          end
          clhs_pkg::PH_SESSION: begin
            st_nxt.phase          = clhs_pkg::PH_IDLE;
            result.kind           = clhs_pkg::KIND_DONE;
            result.status         = clhs_pkg::STATUS_FOUND;
            result.newest_block   = clhs_pkg::field_t'(st.found_block);
            result.newest_block_id = clhs_pkg::field_t'(st.found_id);
            result.session_id     = clhs_pkg::field_t'(st.found_session_id);
            result.session_first  = clhs_pkg::field_t'(st.found_session_first);
            result.session_next   = item.hdr_next_session_first;
            result.session_length = clhs_pkg::field_t'(sess_len);
          end
          default: begin
            has_result = 1'b0;
          end
        endcase
      end
    end

    if (do_split) begin
      result.kind = clhs_pkg::KIND_REQUEST;
      if (sp.done) begin
        st_nxt.found_block         = cand_block;
        st_nxt.found_id            = cand_id;
        st_nxt.found_session_id    = cand_sid;
        st_nxt.found_session_first = cand_sfirst;
        st_nxt.phase               = clhs_pkg::PH_SESSION;
        result.read_block          = clhs_pkg::field_t'(cand_sfirst);
      end else begin
        st_nxt.middle_block = sp.mid;
        st_nxt.phase        = clhs_pkg::PH_SEARCH;
        result.read_block   = clhs_pkg::field_t'(sp.mid);
      end
    end
  end

endmodule

// ===== hw/rtl/circular_log_head_search.sv =====
// Top level of the circular log head search: input register, step logic, result register.
`timescale 1ns / 1ps

// Takes one item per clock while in_stall is low. An accepted item lands in
// the input register and is worked on by the step logic in the following
// cycle. Its result, if any, enters the result register once it is free
// or draining. The input register frees as soon as the result register can
// take a new value, so items stream at one per cycle unless the result side
// stalls. A start item always answers with a read request for block 0; each
// header response answers with the next read request or the final answer; a
// response while no search runs is dropped without a result.
module circular_log_head_search (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_mode,
  input  logic       in_read_ok,
  input  logic       in_magic_valid,
  input  logic [31:0] in_block_id,
  input  logic [31:0] in_hdr_session_id,
  input  logic [31:0] in_hdr_session_first,
  input  logic [31:0] in_hdr_next_session_first,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_kind,
  output logic [31:0] out_read_block,
  output logic [1:0] out_status,
  output logic [31:0] out_newest_block,
  output logic [31:0] out_newest_block_id,
  output logic [31:0] out_session_id,
  output logic [31:0] out_session_first,
  output logic [31:0] out_session_next,
  output logic [31:0] out_session_length
);

  clhs_pkg::field_t        log_size_r;
  clhs_pkg::search_state_t st_r;
  clhs_pkg::search_state_t st_nxt;
  logic                    in_valid_r;
  clhs_pkg::in_item_t      item_r;
  logic                    out_valid_r;
  clhs_pkg::result_t       res_r;
  clhs_pkg::result_t       res_nxt;
  logic                    has_result;
  logic                    fire;
  logic                    in_take;

  // Advance the held item only when the result register is free or draining.
  assign fire     = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !fire;
  assign in_take  = in_valid && !in_stall;

  clhs_step u_step (
    .st         (st_r),
    .item       (item_r),
    .log_size   (log_size_r),
    .st_nxt     (st_nxt),
    .has_result (has_result),
    .result     (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log_size_r <= clhs_pkg::field_t'(2);
    end else if (cfg_wr_en) begin
      log_size_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.mode                   <= in_mode;
      item_r.read_ok                <= in_read_ok;
      item_r.magic_valid            <= in_magic_valid;
      item_r.block_id               <= in_block_id;
      item_r.hdr_session_id         <= in_hdr_session_id;
      item_r.hdr_session_first      <= in_hdr_session_first;
      item_r.hdr_next_session_first <= in_hdr_next_session_first;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // all zero: phase comes up idle
      st_r <= '0;
    end else if (fire) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= has_result;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && has_result) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_kind            = res_r.kind;
  assign out_read_block      = res_r.read_block;
  assign out_status          = res_r.status;
  assign out_newest_block    = res_r.newest_block;
  assign out_newest_block_id = res_r.newest_block_id;
  assign out_session_id      = res_r.session_id;
  assign out_session_first   = res_r.session_first;
  assign out_session_next    = res_r.session_next;
  assign out_session_length  = res_r.session_length;

endmodule

// ===== tb/sv/circular_log_head_search_tb.sv =====
// Self-checking testbench for the circular log head search block.
`timescale 1ns / 1ps

module circular_log_head_search_tb;
  import clhs_pkg::*;

  localparam int HOLD_CYCLES = 300;

  typedef enum logic [1:0] {
    LOG_EMPTY,
    LOG_PARTIAL,
    LOG_FULL
  } log_shape_t;

  // Bisection state as the block keeps it between header responses.
  typedef struct {
    phase_t phase;
    logic   circular;
    bn_t    lo_blk;
    bn_t    hi_blk;
    bn_t    mid_blk;
    uid_t   lo_id;
    uid_t   hi_id;
    uid_t   lo_sid;
    bn_t    lo_first;
    bn_t    hit_blk;
    uid_t   hit_id;
    uid_t   hit_sid;
    bn_t    hit_first;
  } walk_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_mode = 1'b0;
  logic        in_read_ok = 1'b0;
  logic        in_magic_valid = 1'b0;
  logic [31:0] in_block_id = '0;
  logic [31:0] in_hdr_session_id = '0;
  logic [31:0] in_hdr_session_first = '0;
  logic [31:0] in_hdr_next_session_first = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_kind;
  logic [31:0] out_read_block;
  logic [1:0]  out_status;
  logic [31:0] out_newest_block;
  logic [31:0] out_newest_block_id;
  logic [31:0] out_session_id;
  logic [31:0] out_session_first;
  logic [31:0] out_session_next;
  logic [31:0] out_session_length;

  circular_log_head_search dut (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .cfg_wr_en                 (cfg_wr_en),
    .cfg_wr_data               (cfg_wr_data),
    .in_valid                  (in_valid),
    .in_stall                  (in_stall),
    .in_mode                   (in_mode),
    .in_read_ok                (in_read_ok),
    .in_magic_valid            (in_magic_valid),
    .in_block_id               (in_block_id),
    .in_hdr_session_id         (in_hdr_session_id),
    .in_hdr_session_first      (in_hdr_session_first),
    .in_hdr_next_session_first (in_hdr_next_session_first),
    .out_valid                 (out_valid),
    .out_stall                 (out_stall),
    .out_kind                  (out_kind),
    .out_read_block            (out_read_block),
    .out_status                (out_status),
    .out_newest_block          (out_newest_block),
    .out_newest_block_id       (out_newest_block_id),
    .out_session_id            (out_session_id),
    .out_session_first         (out_session_first),
    .out_session_next          (out_session_next),
    .out_session_length        (out_session_length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  in_item_t    header_items[$];
  result_t     expected_answers[$];
  walk_t       dut_walk;
  walk_t       feed_walk;
  logic [31:0] log_size_reg = 32'd2;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned mismatch_count = 0;

  // Shape of the log that the generated header responses describe.
  log_shape_t      shape;
  longint unsigned shape_n = 2;
  longint unsigned shape_fill = 1;
  longint unsigned shape_head = 0;
  field_t          shape_base = '0;
  bn_t             last_req = '0;

  // Close the interval or split it; either way issue the next read.
  function automatic void bisect_next(inout walk_t w, inout result_t r);
    bn_t span;
    span = w.hi_blk - w.lo_blk;
    if (bn_t'(w.lo_blk + bn_t'(1)) == w.hi_blk) begin
      w.hit_blk   = w.lo_blk;
      w.hit_id    = w.lo_id;
      w.hit_sid   = w.lo_sid;
      w.hit_first = w.lo_first;
      w.phase     = PH_SESSION;
      r.read_block = w.hit_first;
    end else begin
      w.mid_blk = w.lo_blk + (span >> 1);
      w.phase   = PH_SEARCH;
      r.read_block = w.mid_blk;
    end
  endfunction

  function automatic bit head_search_step(inout walk_t w, input in_item_t it,
                                          input logic [31:0] size_reg, output result_t r);
    bn_t    n_eff;
    logic   go_left;
    field_t len;
    r = '0;
    n_eff = (size_reg < 32'd2) ? bn_t'(2) : bn_t'(size_reg);
    if (it.mode == MODE_START) begin
      w.lo_blk   = '0;
      w.hi_blk   = n_eff - bn_t'(1);
      w.circular = 1'b0;
      w.phase    = PH_FIRST;
      r.kind     = KIND_REQUEST;
      r.read_block = '0;
      return 1'b1;
    end
    if (w.phase == PH_IDLE)
      return 1'b0;
    if (!it.read_ok) begin
      w.phase  = PH_IDLE;
      r.kind   = KIND_DONE;
      r.status = STATUS_RDERR;
      return 1'b1;
    end
    case (w.phase)
      PH_FIRST: begin
        if (!it.magic_valid) begin
          w.phase  = PH_IDLE;
          r.kind   = KIND_DONE;
          r.status = STATUS_EMPTY;
        end else begin
          w.lo_id    = it.block_id;
          w.lo_sid   = it.hdr_session_id;
          w.lo_first = it.hdr_session_first;
          w.phase    = PH_LAST;
          r.read_block = w.hi_blk;
        end
      end
      PH_LAST: begin
        if (!it.magic_valid) begin
          w.circular = 1'b0;
          bisect_next(w, r);
        end else begin
          w.hi_id = it.block_id;
          // IDs that do not continue across the border put the head at the last block
          if (uid_t'(it.block_id + uid_t'(1)) != w.lo_id) begin
            w.hit_blk   = w.hi_blk;
            w.hit_id    = it.block_id;
            w.hit_sid   = it.hdr_session_id;
            w.hit_first = it.hdr_session_first;
            w.phase     = PH_SESSION;
            r.read_block = w.hit_first;
          end else begin
            w.circular = 1'b1;
            bisect_next(w, r);
          end
        end
      end
      PH_SEARCH: begin
        if (w.circular)
          go_left = uid_t'(it.block_id - w.lo_id) > uid_t'(w.hi_id - it.block_id);
        else
          go_left = !it.magic_valid;
        if (go_left) begin
          w.hi_blk = w.mid_blk;
          w.hi_id  = it.block_id;
        end else begin
          w.lo_blk   = w.mid_blk;
          w.lo_id    = it.block_id;
          w.lo_sid   = it.hdr_session_id;
          w.lo_first = it.hdr_session_first;
        end
        bisect_next(w, r);
      end
      default: begin
        len = '0;
        if (it.hdr_next_session_first != LINK_UNSET) begin
          if (w.hit_blk >= w.hit_first)
            len = w.hit_blk - w.hit_first + field_t'(1);
          else
            len = w.hit_blk + n_eff - w.hit_first + field_t'(1);
        end
        w.phase           = PH_IDLE;
        r.kind            = KIND_DONE;
        r.status          = STATUS_FOUND;
        r.newest_block    = w.hit_blk;
        r.newest_block_id = w.hit_id;
        r.session_id      = w.hit_sid;
        r.session_first   = w.hit_first;
        r.session_next    = it.hdr_next_session_first;
        r.session_length  = len;
      end
    endcase
    return 1'b1;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it.mode                   = 1'($urandom);
    it.read_ok                = 1'($urandom);
    it.magic_valid            = 1'($urandom);
    it.block_id               = $urandom;
    it.hdr_session_id         = $urandom;
    it.hdr_session_first      = $urandom;
    it.hdr_next_session_first = $urandom;
    return it;
  endfunction

  // Header of a block in the current log shape, with occasional corruption.
  function automatic in_item_t header_for(bn_t blk);
    in_item_t        it;
    longint unsigned b;
    longint unsigned o;
    longint unsigned d;
    logic            present;
    b = blk % shape_n;
    it = random_item();
    it.mode    = ~MODE_START;
    it.read_ok = ($urandom_range(99) >= 3);
    case (shape)
      LOG_EMPTY:   present = 1'b0;
      LOG_PARTIAL: present = (b < shape_fill);
      default:     present = 1'b1;
    endcase
    it.magic_valid = ($urandom_range(99) < 3) ? !present : present;
    if (shape == LOG_FULL) begin
      o = (shape_head + 1) % shape_n;
      it.block_id = shape_base + field_t'((b + shape_n - o) % shape_n);
    end else if (shape == LOG_PARTIAL) begin
      it.block_id = shape_base + field_t'(b);
    end
    d = $urandom_range(0, 20) % shape_n;
    if ($urandom_range(99) >= 5)
      it.hdr_session_first = field_t'((b >= d) ? b - d : b + shape_n - d);
    if ($urandom_range(99) < 30)
      it.hdr_next_session_first = LINK_UNSET;
    return it;
  endfunction

  task automatic new_shape();
    int unsigned pick;
    shape_n = (log_size_reg < 32'd2) ? 64'd2 : longint'(log_size_reg);
    pick = $urandom_range(99);
    shape = (pick < 10) ? LOG_EMPTY : (pick < 45) ? LOG_PARTIAL : LOG_FULL;
    shape_fill = 1 + ({$urandom, $urandom} % (shape_n - 1));
    pick = $urandom_range(99);
    if (pick < 20)
      shape_head = shape_n - 1;
    else if (pick < 30)
      shape_head = 0;
    else
      shape_head = {$urandom, $urandom} % shape_n;
    shape_base = ($urandom_range(99) < 20) ? 32'hFFFF_FFFF - $urandom_range(0, 40) : $urandom;
  endtask

  // Track the search on the sending side so the next response answers the last read.
  task automatic queue_item(input in_item_t it, output bit counted);
    result_t r;
    counted = (it.mode == MODE_START) || (feed_walk.phase != PH_IDLE);
    if (head_search_step(feed_walk, it, log_size_reg, r) && r.kind == KIND_REQUEST)
      last_req = r.read_block;
    header_items.push_back(it);
  endtask

  task automatic offer(logic mode, logic ok, logic magic, field_t bid, field_t sid,
                       field_t sfirst, field_t snext);
    in_item_t it;
    bit       counted;
    it = '{mode, ok, magic, bid, sid, sfirst, snext};
    queue_item(it, counted);
  endtask

  task automatic fill_random(int unsigned n);
    int unsigned taken;
    in_item_t    it;
    bit          counted;
    taken = 0;
    while (taken < n) begin
      if (feed_walk.phase == PH_IDLE) begin
        it = random_item();
        if ($urandom_range(99) < 5) begin
          it.mode = ~MODE_START;
        end else begin
          new_shape();
          it.mode = MODE_START;
        end
      end else if ($urandom_range(99) < 2) begin
        // drop the running search
        new_shape();
        it = random_item();
        it.mode = MODE_START;
      end else if ($urandom_range(99) < 3) begin
        it = random_item();
        it.mode = ~MODE_START;
      end else begin
        it = header_for(last_req);
      end
      queue_item(it, counted);
      if (counted)
        taken++;
    end
  endtask

  task automatic wait_quiet();
    int unsigned guard;
    while (header_items.size() != 0 || in_valid)
      @(negedge clk);
    guard = 0;
    while (expected_answers.size() != 0 && guard < 5000) begin
      @(negedge clk);
      guard++;
    end
    // let dropped responses still in the pipe clear out
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(logic [31:0] size, int unsigned idle_pct,
                           int unsigned stall_p, int unsigned n);
    wait_quiet();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= size;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    log_size_reg = size;
    @(negedge clk);
    send_idle_pct = idle_pct;
    stall_pct     = stall_p;
    fill_random(n);
  endtask

  // Sender: offer the next header item, hold it until taken.
  always @(posedge clk) begin : drive_items
    result_t  answer;
    in_item_t cur;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        cur = '{in_mode, in_read_ok, in_magic_valid, in_block_id, in_hdr_session_id,
                in_hdr_session_first, in_hdr_next_session_first};
        if (head_search_step(dut_walk, cur, log_size_reg, answer))
          expected_answers.push_back(answer);
      end
      if (!in_valid || !in_stall) begin
        if (header_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur = header_items.pop_front();
          in_valid                  <= 1'b1;
          in_mode                   <= cur.mode;
          in_read_ok                <= cur.read_ok;
          in_magic_valid            <= cur.magic_valid;
          in_block_id               <= cur.block_id;
          in_hdr_session_id         <= cur.hdr_session_id;
          in_hdr_session_first      <= cur.hdr_session_first;
          in_hdr_next_session_first <= cur.hdr_next_session_first;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls plus a long hold-off whenever one is asked for.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      out_stall   <= 1'b1;
      hold_served <= hold_served + 1;
      hold_left   <= HOLD_CYCLES;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : check_answers
    result_t got;
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_kind, out_read_block, out_status, out_newest_block, out_newest_block_id,
             out_session_id, out_session_first, out_session_next, out_session_length};
      if (expected_answers.size() == 0) begin
        if (mismatch_count < 10)
          $display("%0t: result with nothing expected: %p", $realtime, got);
        mismatch_count++;
      end else begin
        want = expected_answers.pop_front();
        if (got !== want) begin
          if (mismatch_count < 10)
            $display("%0t: mismatch\n  expected %p\n  actual   %p", $realtime, want, got);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    dut_walk  = '{phase: PH_IDLE, default: '0};
    feed_walk = '{phase: PH_IDLE, default: '0};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // response with no search running: dropped; then a start and a read error
    offer(1, 1, 1, '1, '1, '1, '1);
    offer(0, 1, 1, '1, '1, '1, '1);
    offer(1, 0, 1, 0, 0, 0, 0);
    // empty log
    offer(0, 0, 0, 0, 0, 0, 0);
    offer(1, 1, 0, 0, 0, 0, 0);
    // IDs break at the border; session first lies past the head, length wraps
    offer(0, 0, 0, 0, 0, 0, 0);
    offer(1, 1, 1, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
    offer(1, 1, 1, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    offer(1, 1, 0, 32'h0, 32'h0, 32'h0, 32'h0);
    // IDs continue across the border, forward link unset
    offer(0, 0, 0, 0, 0, 0, 0);
    offer(1, 1, 1, 32'd7, 32'h1234_5678, 32'd0, 32'd0);
    offer(1, 1, 1, 32'd6, 32'd0, 32'd0, 32'd0);
    offer(1, 1, 1, 32'd0, 32'd0, 32'd0, LINK_UNSET);
    // last block invalid, then a restart while the session read is pending
    offer(0, 0, 0, 0, 0, 0, 0);
    offer(1, 1, 1, 32'd3, 32'd9, 32'd1, 32'd0);
    offer(1, 1, 0, 32'd0, 32'd0, 32'd0, 32'd0);
    offer(0, 1, 1, 32'd5, 32'd5, 32'd5, 32'd5);
    offer(1, 1, 1, 32'd4, 32'd4, 32'd0, 32'd0);
    offer(1, 0, 1, 32'd5, 32'd5, 32'd0, 32'd0);
    // read error on the session block
    offer(0, 0, 0, 0, 0, 0, 0);
    offer(1, 1, 1, 32'd10, 32'd2, 32'd1, 32'd0);
    offer(1, 1, 1, 32'd20, 32'd2, 32'd1, 32'd0);
    offer(1, 0, 1, 32'd0, 32'd0, 32'd0, 32'd3);

    run_phase(32'd0, 0, 0, 80);
    run_phase(32'd13, 80, 0, 150);
    run_phase(32'd1, 0, 80, 80);
    run_phase(32'd64, 22, 22, 150);
    // long receiver hold-off while items keep coming
    hold_asked++;
    fill_random(150);
    // sender pause until every result is back
    wait_quiet();
    fill_random(60);
    run_phase(32'hFFFF_FFFF, 0, 0, 200);
    run_phase($urandom, 22, 22, 150);
    run_phase(32'd3, 0, 0, 200);
    run_phase(32'd2, 80, 0, 120);
    wait_quiet();
    repeat (10) @(posedge clk);

    if (mismatch_count == 0 && expected_answers.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== circular_log_head_search.f =====
hw/rtl/clhs_pkg.sv
hw/rtl/clhs_step.sv
hw/rtl/circular_log_head_search.sv
tb/sv/circular_log_head_search_tb.sv
